// ----- src/dtcr_pkg.sv -----
package dtcr_pkg;

   localparam int TIMER_COUNT_DEF = 2;
   localparam int DATA_W          = 32;
   localparam int CSR_W           = 11;
   localparam int ADDR_W          = 3;

   // control/status bit positions
   localparam int CSR_UP_BIT     = 1;
   localparam int CSR_RELOAD_BIT = 4;
   localparam int CSR_IRQ_EN_BIT = 6;
   localparam int CSR_ENABLE_BIT = 7;
   localparam int CSR_FLAG_BIT   = 8;

   localparam logic [CSR_W-1:0] CSR_MASK = 11'h7ff;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_WRITE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      REG_CONTROL = 2'd0,
      REG_LOAD    = 2'd1,
      REG_COUNTER = 2'd2,
      REG_SPARE   = 2'd3
   } reg_sel_type;

endpackage

// ----- src/dual_timer_counter_registers_core.sv -----
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_mode, req_word_address, req_write_data
// rsp       out        rsp_valid/rsp_stall  rsp_read_data, rsp_irq
// csr       in         csr_valid/csr_ready  csr_single_timer
//
// One item per cycle while rsp is not stalled; each item passes the input register,
// then the timer update into the result register.
// The timer state update and result are produced in one pass between the two registers.
// Synchronous active-high reset clears all timer state, the mode bit and both valids.
// A stalled rsp holds the result; one more item waits in the input register,
// after which req_stall rises.
module dual_timer_counter_registers_core
   import dtcr_pkg::*;
#(
   parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_mode,
   input  logic [ADDR_W-1:0] req_word_address,
   input  logic [DATA_W-1:0] req_write_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DATA_W-1:0] rsp_read_data,
   output logic              rsp_irq,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_single_timer
);

   logic              single_ff;
   logic              in_valid_ff;
   logic [1:0]        in_mode_ff;
   logic [ADDR_W-1:0] in_addr_ff;
   logic [DATA_W-1:0] in_data_ff;
   logic              out_valid_ff;
   logic [DATA_W-1:0] out_data_ff;
   logic              out_irq_ff;

   logic              out_free;
   logic              advance;
   logic              is_tick;
   logic              is_read;
   logic              is_write;
   reg_sel_type       reg_sel;
   logic [DATA_W-1:0] read_data;
   logic              irq_next;

   logic [CSR_W-1:0]  ctrl_ff    [TIMER_COUNT];
   logic [CSR_W-1:0]  ctrl_in    [TIMER_COUNT];
   logic [DATA_W-1:0] load_ff    [TIMER_COUNT];
   logic [DATA_W-1:0] load_in    [TIMER_COUNT];
   logic [DATA_W-1:0] spare_ff   [TIMER_COUNT];
   logic [DATA_W-1:0] spare_in   [TIMER_COUNT];
   logic [DATA_W-1:0] count_ff   [TIMER_COUNT];
   logic [DATA_W-1:0] count_in   [TIMER_COUNT];
   logic              running_ff [TIMER_COUNT];
   logic              running_in [TIMER_COUNT];
   logic [DATA_W-1:0] rd_part    [TIMER_COUNT];
   logic              irq_part   [TIMER_COUNT];

   assign csr_ready = 1'b1;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   assign is_tick  = (in_mode_ff == MODE_TICK);
   assign is_read  = (in_mode_ff == MODE_READ);
   assign is_write = (in_mode_ff == MODE_WRITE);
   assign reg_sel  = reg_sel_type'(in_addr_ff[1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         single_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         single_ff <= csr_single_timer;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_mode_ff <= req_mode;
         in_addr_ff <= req_word_address;
         in_data_ff <= req_write_data;
      end
   end

   for (genvar i = 0; i < TIMER_COUNT; i++) begin : g_timer
      logic              active;
      logic              selected;
      logic              up;
      logic [DATA_W-1:0] term;
      logic [DATA_W-1:0] stepped;
      logic              hit;

      assign active   = (i == 0) || !single_ff;
      assign selected = active && (in_addr_ff[2] == 1'(i));
      assign up       = ctrl_ff[i][CSR_UP_BIT];
      assign term     = up ? '1 : '0;
      assign stepped  = (count_ff[i] == term) ? count_ff[i] :
                        (up ? count_ff[i] + 1'b1 : count_ff[i] - 1'b1);
      assign hit      = (stepped == term);

      always_comb begin
         ctrl_in[i]    = ctrl_ff[i];
         load_in[i]    = load_ff[i];
         spare_in[i]   = spare_ff[i];
         count_in[i]   = count_ff[i];
         running_in[i] = running_ff[i];
         rd_part[i]    = '0;
         if (is_tick && active && running_ff[i]) begin
            count_in[i] = stepped;
            if (hit) begin
               ctrl_in[i][CSR_FLAG_BIT] = 1'b1;
               if (ctrl_ff[i][CSR_RELOAD_BIT]) begin
                  count_in[i] = load_ff[i];
               end else begin
                  running_in[i] = 1'b0;
               end
            end
         end
         if (is_read && selected) begin
            unique case (reg_sel)
               REG_CONTROL: rd_part[i] = DATA_W'(ctrl_ff[i]);
               REG_LOAD:    rd_part[i] = load_ff[i];
               REG_COUNTER: rd_part[i] = count_ff[i];
               REG_SPARE:   rd_part[i] = spare_ff[i];
            endcase
         end
         if (is_write && selected) begin
            unique case (reg_sel)
               REG_CONTROL: begin
                  ctrl_in[i] = in_data_ff[CSR_W-1:0] & CSR_MASK;
                  ctrl_in[i][CSR_FLAG_BIT] = 1'b0;
                  if (in_data_ff[CSR_ENABLE_BIT]) begin
                     count_in[i]   = load_ff[i];
                     running_in[i] = 1'b1;
                  end else begin
                     running_in[i] = 1'b0;
                  end
               end
               REG_LOAD:    load_in[i]  = in_data_ff;
               REG_COUNTER: ;  // drop: counter reads always show the live count
               REG_SPARE:   spare_in[i] = in_data_ff;
            endcase
         end
         irq_part[i] = active && ctrl_in[i][CSR_FLAG_BIT] && ctrl_in[i][CSR_IRQ_EN_BIT];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctrl_ff[i]    <= '0;
            load_ff[i]    <= '0;
            spare_ff[i]   <= '0;
            count_ff[i]   <= '0;
            running_ff[i] <= 1'b0;
         end else if (advance) begin
            ctrl_ff[i]    <= ctrl_in[i];
            load_ff[i]    <= load_in[i];
            spare_ff[i]   <= spare_in[i];
            count_ff[i]   <= count_in[i];
            running_ff[i] <= running_in[i];
         end
      end
   end

   always_comb begin
      read_data = '0;
      irq_next  = 1'b0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
         read_data = read_data | rd_part[i];
         irq_next  = irq_next | irq_part[i];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= read_data;
         out_irq_ff  <= irq_next;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_data_ff;
   assign rsp_irq       = out_irq_ff;

endmodule
